// ===== rtl/core/selective_repeat_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// Selective-repeat receiver assertion macros
// Shared property wrappers for the receiver's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVER_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/srr_pkg.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat receiver package
// Field widths, result kind codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package srr_pkg;

	// Fixed field widths of the packet and result ports.
	localparam int SEQ_W     = 3;
	localparam int PAYLOAD_W = 64;

	// Result kind codes.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;   // Take the incoming packet and store it.
		logic retire;    // The head data result was taken; retire its slot.
		logic show_ack;  // Present the acknowledgement on the result port.
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic head_valid;  // The slot at the window base holds a packet.
	} status_t;

endpackage

// ===== rtl/core/srr_ctrl.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat receiver controller
// Sequences packet capture, in-order release of buffered packets and the ack.
// ----------------------------------------------------------------------------
module srr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  srr_pkg::status_t status,
	output srr_pkg::cmd_t    cmd
);
	import srr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DATA,
		ST_ACK
	} state_t;

	state_t state_q;

	// State register: load the head slot, emit data while the head is valid,
	// then emit the acknowledgement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					state_q <= status.head_valid ? ST_DATA : ST_ACK;
				end
				ST_DATA: begin
					if (!out_stall) state_q <= ST_LOAD;
				end
				ST_ACK: begin
					if (!out_stall) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Handshake and command decode.
	always_comb begin
		in_stall     = (state_q != ST_IDLE);
		out_valid    = (state_q == ST_DATA) || (state_q == ST_ACK);
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.retire   = (state_q == ST_DATA) && !out_stall;
		cmd.show_ack = (state_q == ST_ACK);
	end

endmodule

// ===== rtl/core/srr_datapath.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat receiver datapath
// Window base, slot valid bits, payload slot memory and result formatting.
// ----------------------------------------------------------------------------
module srr_datapath #(
	parameter int WINDOW        = 4,
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  srr_pkg::cmd_t                  cmd,
	output srr_pkg::status_t               status,
	input  logic [srr_pkg::SEQ_W-1:0]      seq_num,
	input  logic                           final_packet,
	input  logic [srr_pkg::PAYLOAD_W-1:0]  payload_word,
	output logic                           result_kind,
	output logic [srr_pkg::SEQ_W-1:0]      result_seq,
	output logic [srr_pkg::PAYLOAD_W-1:0]  result_payload,
	output logic                           run_end,
	output logic                           transfer_done
);
	import srr_pkg::*;

	localparam int SEQ_MOD = 2 * WINDOW;
	localparam int BASE_W  = $clog2(SEQ_MOD);
	localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int DATA_W  = 8 * PAYLOAD_BYTES;

	logic [BASE_W-1:0] base_q;
	logic [WINDOW-1:0] valid_q;
	logic              last_seen_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [DATA_W-1:0] mem [WINDOW];
	logic [DATA_W-1:0] rd_q;

	logic [SEQ_W-1:0]  seq_m;
	logic [BASE_W-1:0] seq_b;
	logic [BASE_W:0]   offset;
	logic              in_window;
	logic [SLOT_W-1:0] wr_slot;
	logic [SLOT_W-1:0] head_slot;
	logic [BASE_W-1:0] base_next;

	// Reduce a 3-bit sequence number modulo the sequence space.
	function automatic logic [SEQ_W-1:0] seq_wrap(input logic [SEQ_W-1:0] v);
		logic [SEQ_W-1:0] r;
		r = v;
		for (int i = 0; i < 4; i++) begin
			if (int'(r) >= SEQ_MOD) r = r - SEQ_W'(SEQ_MOD);
		end
		return r;
	endfunction

	// Offset from the base and slot indexes.
	always_comb begin
		seq_m     = seq_wrap(seq_num);
		seq_b     = BASE_W'(seq_m);
		offset    = {1'b0, seq_b}
			+ ((seq_b < base_q) ? (BASE_W + 1)'(SEQ_MOD) : '0)
			- {1'b0, base_q};
		in_window = offset < (BASE_W + 1)'(WINDOW);
		wr_slot   = (seq_b >= BASE_W'(WINDOW)) ? SLOT_W'(seq_b - BASE_W'(WINDOW))
			: SLOT_W'(seq_b);
		head_slot = (base_q >= BASE_W'(WINDOW)) ? SLOT_W'(base_q - BASE_W'(WINDOW))
			: SLOT_W'(base_q);
		base_next = (base_q == BASE_W'(SEQ_MOD - 1)) ? '0 : base_q + 1'b1;
	end

	// Window control state: base, valid bits and the last-packet flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q      <= '0;
			valid_q     <= '0;
			last_seen_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				if (final_packet) last_seen_q <= 1'b1;
				if (in_window) valid_q[wr_slot] <= 1'b1;
			end
			if (cmd.retire) begin
				valid_q[head_slot] <= 1'b0;
				base_q             <= base_next;
			end
		end
	end

	// Sequence number held for the acknowledgement.
	always_ff @(posedge clk) begin
		if (cmd.capture) seq_q <= seq_m;
	end

	// Payload slot memory: one write port, one registered read at the head.
	always_ff @(posedge clk) begin
		if (cmd.capture && in_window) mem[wr_slot] <= payload_word[DATA_W-1:0];
		rd_q <= mem[head_slot];
	end

	// Result formatting.
	always_comb begin
		status.head_valid = valid_q[head_slot];
		result_kind       = cmd.show_ack ? KIND_ACK : KIND_DATA;
		result_seq        = cmd.show_ack ? seq_q : SEQ_W'(base_q);
		result_payload    = cmd.show_ack ? '0 : PAYLOAD_W'(rd_q);
		run_end           = cmd.show_ack;
		transfer_done     = cmd.show_ack && last_seen_q && !(|valid_q);
	end

endmodule

// ===== rtl/core/selective_repeat_receiver.sv =====
// Sequencing: a taken packet request moves the controller from idle to a load state that
// reads the head slot. Each in-order data result is a head slot read in the load state,
// then presented in the data state; the acknowledgement follows a further load, in the
// ack state. Output stalls hold the data and ack states. The next request is taken only
// back in idle, once the ack is taken. Reset clears base, valid bits, last flag and
// control; payload slots are not.
// ----------------------------------------------------------------------------
// Selective-repeat receiver
// Buffers packets within the receive window and releases them in order,
// closing each request with an acknowledgement.
// ----------------------------------------------------------------------------
`include "selective_repeat_receiver_macros.svh"

module selective_repeat_receiver #(
	parameter int WINDOW        = 4,
	parameter int PAYLOAD_BYTES = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [srr_pkg::SEQ_W-1:0]      seq_num,
	input  logic                           final_packet,
	input  logic [srr_pkg::PAYLOAD_W-1:0]  payload_word,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           result_kind,
	output logic [srr_pkg::SEQ_W-1:0]      result_seq,
	output logic [srr_pkg::PAYLOAD_W-1:0]  result_payload,
	output logic                           run_end,
	output logic                           transfer_done
);
	import srr_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Controller.
	srr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath.
	srr_datapath #(
		.WINDOW        (WINDOW),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.seq_num        (seq_num),
		.final_packet   (final_packet),
		.payload_word   (payload_word),
		.result_kind    (result_kind),
		.result_seq     (result_seq),
		.result_payload (result_payload),
		.run_end        (run_end),
		.transfer_done  (transfer_done)
	);

	// A taken request is never answered in the same or the next cycle.
	`SRR_ASSERT_NEXT(a_no_result_after_take, in_valid && !in_stall, !out_valid, "result right after request")
	// The receiver is free again once the acknowledgement is taken.
	`SRR_ASSERT_NEXT(a_free_after_ack, out_valid && !out_stall && run_end, !in_stall, "busy after ack")
	// No new request is taken while a result is pending.
	`SRR_ASSERT_SAME(a_stall_while_result, out_valid, in_stall, "request taken with result pending")
	// Data results never close the run or flag completion.
	`SRR_ASSERT_SAME(a_data_flags, out_valid && result_kind == KIND_DATA, !run_end && !transfer_done, "bad flags on data result")

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Selective-repeat receiver testbench
// Streams data packets into the receiver, both in and out of order, with
// stale and stray sequence numbers mixed in. A scoreboard model of the
// receive window predicts every in-order release and acknowledgement.
// Randomized gaps and output stalls are applied, plus one long output hold-off
// that backs up the input.
// ----------------------------------------------------------------------------
module tb;
	import srr_pkg::*;

	localparam int WINDOW        = 4;
	localparam int PAYLOAD_BYTES = 8;
	localparam int SEQ_MOD       = 2 * WINDOW;
	localparam logic [PAYLOAD_W-1:0] PAYLOAD_MASK =
		{PAYLOAD_W{1'b1}} >> (PAYLOAD_W - 8 * PAYLOAD_BYTES);

	localparam int RANDOM_ITEMS  = 170;
	localparam int MAX_REPORTS   = 10;
	localparam int HOLD_AT       = 80;
	localparam int HOLD_CYCLES   = 120;
	localparam int DRAIN_CYCLES  = 20;
	localparam int IDLE_LIMIT    = 2000;

	// One packet request as queued for the driver.
	typedef struct {
		logic [SEQ_W-1:0]     seq;
		logic                 fin;
		logic [PAYLOAD_W-1:0] payload;
		int unsigned          gap;
	} request_t;

	// One result item as seen on the output port.
	typedef struct packed {
		logic                 kind;
		logic [SEQ_W-1:0]     seq;
		logic [PAYLOAD_W-1:0] payload;
		logic                 run_end;
		logic                 done;
	} result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [SEQ_W-1:0]     seq_num = '0;
	logic                 final_packet = 1'b0;
	logic [PAYLOAD_W-1:0] payload_word = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 result_kind;
	logic [SEQ_W-1:0]     result_seq;
	logic [PAYLOAD_W-1:0] result_payload;
	logic                 run_end;
	logic                 transfer_done;

	// Packets waiting to be offered, and the results still owed by the receiver.
	request_t tx_packets[$];
	result_t  awaited_results[$];
	request_t current_req;

	// Scoreboard copy of the receive window.
	int                   rx_base = 0;
	logic [WINDOW-1:0]    rx_valid = '0;
	logic [PAYLOAD_W-1:0] rx_slot[WINDOW];
	logic                 rx_last_seen = 1'b0;

	int          packets_queued = 0;
	int          packets_taken = 0;
	int          results_seen = 0;
	int          failures = 0;
	int unsigned gap_left = 0;
	int unsigned wait_left = 0;
	int unsigned hold_left = 0;
	int unsigned calm_left = 0;
	int unsigned idle_cycles = 0;
	bit          sender_calm = 1'b0;

	selective_repeat_receiver #(
		.WINDOW        (WINDOW),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.seq_num        (seq_num),
		.final_packet   (final_packet),
		.payload_word   (payload_word),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.result_seq     (result_seq),
		.result_payload (result_payload),
		.run_end        (run_end),
		.transfer_done  (transfer_done)
	);

	// Store an accepted packet, release the in-order run from the base and
	// close with the acknowledgement.
	task automatic predict_release(input request_t req);
		int offset;
		int n;
		result_t r;
		if (req.fin) begin
			rx_last_seen = 1'b1;
		end
		offset = (int'(req.seq) + SEQ_MOD - rx_base) % SEQ_MOD;
		if (offset < WINDOW) begin
			rx_valid[int'(req.seq) % WINDOW] = 1'b1;
			rx_slot[int'(req.seq) % WINDOW] = req.payload & PAYLOAD_MASK;
		end
		for (n = 0; n < WINDOW && rx_valid[rx_base % WINDOW]; n++) begin
			r = '{kind: KIND_DATA, seq: SEQ_W'(rx_base), payload: rx_slot[rx_base % WINDOW],
				run_end: 1'b0, done: 1'b0};
			awaited_results.push_back(r);
			rx_valid[rx_base % WINDOW] = 1'b0;
			rx_base = (rx_base + 1) % SEQ_MOD;
		end
		r = '{kind: KIND_ACK, seq: req.seq, payload: '0, run_end: 1'b1,
			done: rx_last_seen && !(|rx_valid)};
		awaited_results.push_back(r);
	endtask

	// Append a packet to the send queue with its own idle gap.
	task automatic queue_packet(input int seq, input logic fin, input logic [PAYLOAD_W-1:0] pay);
		request_t req;
		req.seq = SEQ_W'(seq % SEQ_MOD);
		req.fin = fin;
		req.payload = pay;
		req.gap = sender_calm ? 0 : $urandom_range(0, 8);
		tx_packets.push_back(req);
	endtask

	// Payload with the all-zero and all-one words drawn now and then.
	function automatic logic [PAYLOAD_W-1:0] draw_payload();
		case ($urandom_range(0, 15))
			0: draw_payload = '0;
			1: draw_payload = '1;
			default: draw_payload = {$urandom, $urandom};
		endcase
	endfunction

	// Free-running clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Driver: offer queued packet requests and hand accepted ones to the scoreboard.
	always @(posedge clk) begin : drive_requests
		logic offering;
		if (arst_n) begin
			offering = in_valid;
			if (in_valid && !in_stall) begin
				predict_release(current_req);
				packets_taken++;
				offering = 1'b0;
			end
			if (!offering) begin
				if (gap_left != 0) begin
					gap_left--;
				end else if (tx_packets.size() != 0) begin
					current_req = tx_packets.pop_front();
					gap_left = current_req.gap;
					offering = 1'b1;
					seq_num <= current_req.seq;
					final_packet <= current_req.fin;
					payload_word <= current_req.payload;
				end
			end
			in_valid <= offering;
		end
	end

	// Monitor: compare each taken result with the oldest expectation and pace
	// the output stall, including one long hold-off.
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{kind: result_kind, seq: result_seq, payload: result_payload,
					run_end: run_end, done: transfer_done};
				if (awaited_results.size() == 0) begin
					failures++;
					if (failures <= MAX_REPORTS) begin
						$display("tb: unexpected result kind=%0d seq=%0d payload=%h end=%0d done=%0d",
							got.kind, got.seq, got.payload, got.run_end, got.done);
					end
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						failures++;
						if (failures <= MAX_REPORTS) begin
							$display("tb: mismatch expected kind=%0d seq=%0d payload=%h end=%0d done=%0d",
								want.kind, want.seq, want.payload, want.run_end, want.done);
							$display("tb:          actual kind=%0d seq=%0d payload=%h end=%0d done=%0d",
								got.kind, got.seq, got.payload, got.run_end, got.done);
						end
					end
				end
				results_seen++;
				if (results_seen == HOLD_AT) begin
					hold_left = HOLD_CYCLES;
				end
				if (calm_left != 0) begin
					calm_left--;
					wait_left = 0;
				end else begin
					wait_left = $urandom_range(0, 8);
					if ($urandom_range(0, 15) == 0) begin
						calm_left = 24;
					end
				end
			end else begin
				if (wait_left != 0) begin
					wait_left--;
				end
				if (hold_left != 0) begin
					hold_left--;
				end
			end
			out_stall <= (wait_left != 0) || (hold_left != 0);
		end
	end

	// Watchdog: end the run if neither side moves a request for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Stimulus and end of run.
	initial begin : stimulus
		int order[WINDOW];
		int next_block;
		int target;
		int j;
		int tmp;

		// Directed part, base starts at zero.
		queue_packet(0, 1'b0, '1);                     // in order, delivered at once
		queue_packet(0, 1'b0, '0);                     // stale, behind the base
		queue_packet(5, 1'b0, 64'h0123_4567_89ab_cdef); // first number past the window
		queue_packet(4, 1'b0, 64'h4444_0000_4444_0000); // far edge of the window, held
		queue_packet(3, 1'b0, 64'h3333_3333_3333_3333);
		queue_packet(3, 1'b0, 64'hc3c3_c3c3_c3c3_c3c3); // duplicate overwrites its slot
		queue_packet(2, 1'b0, 64'h2222_2222_2222_2222);
		queue_packet(1, 1'b0, 64'h8000_0000_0000_0001); // releases the whole window
		queue_packet(7, 1'b1, 64'h7777_7777_7777_7777); // final flag with slots held
		queue_packet(6, 1'b0, 64'h6666_6666_6666_6666);
		queue_packet(0, 1'b0, 64'hfedc_ba98_7654_3210); // wraps around the number space
		queue_packet(5, 1'b0, 64'h5555_0000_ffff_aaaa); // releases 5, 6, 7, 0 and finishes
		queue_packet(1, 1'b0, '0);                     // traffic after completion
		queue_packet(6, 1'b1, '1);                     // final flag on a discarded packet
		queue_packet(3, 1'b0, 64'h5555_5555_5555_5555);
		queue_packet(2, 1'b0, 64'haaaa_aaaa_aaaa_aaaa);
		next_block = 4;

		// Random part: shuffled windows with duplicates, stale and stray packets.
		target = tx_packets.size() + RANDOM_ITEMS;
		while (tx_packets.size() < target) begin
			sender_calm = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < WINDOW; k++) begin
				order[k] = k;
			end
			for (int k = WINDOW - 1; k > 0; k--) begin
				j = $urandom_range(0, k);
				tmp = order[k];
				order[k] = order[j];
				order[j] = tmp;
			end
			for (int k = 0; k < WINDOW; k++) begin
				if ($urandom_range(0, 5) == 0) begin
					queue_packet(next_block - 1 - $urandom_range(0, WINDOW - 1),
						$urandom_range(0, 7) == 0, draw_payload());
				end
				if ($urandom_range(0, 9) == 0) begin
					queue_packet($urandom_range(0, SEQ_MOD - 1),
						$urandom_range(0, 7) == 0, draw_payload());
				end
				queue_packet(next_block + order[k], $urandom_range(0, 7) == 0, draw_payload());
				if ($urandom_range(0, 4) == 0) begin
					queue_packet(next_block + order[k], $urandom_range(0, 7) == 0,
						draw_payload());
				end
			end
			next_block += WINDOW;
		end
		packets_queued = tx_packets.size();

		// Reset, then let the driver and monitor run.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (packets_taken < packets_queued) begin
			@(posedge clk);
		end
		while (awaited_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (awaited_results.size() != 0) begin
			failures += awaited_results.size();
			$display("tb: %0d expected results never arrived", awaited_results.size());
		end
		if (failures == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
